>>> src/bwb_pkg.sv
package bwb_pkg;

   // configuration register indexes
   localparam int CSR_ADDR_BITS = 1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_ROOM_WIDTH  = 1'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_ROOM_HEIGHT = 1'd1;

   // room size after reset: 5.0 with 16 fraction bits
   localparam int ROOM_RESET = 327680;

   // request opcodes
   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // result kinds
   localparam logic [1:0] KIND_POS    = 2'd0;
   localparam logic [1:0] KIND_IMPACT = 2'd1;
   localparam logic [1:0] KIND_ERR    = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_W,
      ST_SQ_H,
      ST_START_OUT,
      ST_CLAMP,
      ST_EVAL,
      ST_HIT,
      ST_MUL_X,
      ST_DIV_X,
      ST_MUL_Y,
      ST_DIV_Y,
      ST_PLACE,
      ST_MIRROR,
      ST_EMIT_1,
      ST_EMIT_2,
      ST_EMIT_POS
   } state_type;

   typedef enum logic {
      MDU_MUL,
      MDU_DIV
   } mdu_op_type;

   typedef struct packed {
      logic       go;
      mdu_op_type op;
   } mdu_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mdu_sts_type;

endpackage

>>> src/bwb_mdu.sv
// Bit-serial multiply / divide unit built around one shared adder.
// Multiply: opa * opb, one multiplier bit per cycle, COORD_BITS steps.
// Divide: dividend / opa, restoring, COORD_BITS+1 quotient bits; a quotient
// that does not fit in COORD_BITS+1 bits saturates to all ones.
module bwb_mdu #(
   parameter int COORD_BITS = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  bwb_pkg::mdu_cmd_type      cmd,
   input  logic [COORD_BITS-1:0]     opa,
   input  logic [COORD_BITS-1:0]     opb,
   input  logic [2*COORD_BITS-1:0]   dividend,
   output bwb_pkg::mdu_sts_type      sts,
   output logic [2*COORD_BITS-1:0]   result
);

   localparam int N       = COORD_BITS;
   localparam int CntBits = $clog2(N + 1);
   localparam logic [CntBits-1:0] MulLast = CntBits'(N - 1);
   localparam logic [CntBits-1:0] DivLast = CntBits'(N);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   bwb_pkg::mdu_op_type     op_ff, op_in;
   logic [CntBits-1:0]      cnt_ff, cnt_in;
   logic [N:0]              hi_ff, hi_in;
   logic [N:0]              lo_ff, lo_in;
   logic [N-1:0]            a_ff, a_in;
   logic                    sat_ff, sat_in;

   logic                    is_div;
   logic [N:0]              add_x;
   logic [N:0]              add_y;
   logic [N+1:0]            add_sum;

   // shared adder: accumulate for multiply, trial subtract for divide
   always_comb begin
      is_div  = (op_ff == bwb_pkg::MDU_DIV);
      add_x   = is_div ? {hi_ff[N-1:0], lo_ff[N]} : hi_ff;
      add_y   = is_div ? ~{1'b0, a_ff} : (lo_ff[0] ? {1'b0, a_ff} : '0);
      add_sum = {1'b0, add_x} + {1'b0, add_y} + {{(N+1){1'b0}}, is_div};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      a_in    = a_ff;
      sat_in  = sat_ff;
      if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (is_div) begin
            hi_in = add_sum[N+1] ? add_sum[N:0] : add_x;
            lo_in = {lo_ff[N-1:0], add_sum[N+1]};
            if (cnt_ff == DivLast) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end else begin
            hi_in = {1'b0, add_sum[N:1]};
            lo_in = {add_sum[0], lo_ff[N:1]};
            if (cnt_ff == MulLast) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end else if (cmd.go) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         cnt_in  = '0;
         a_in    = opa;
         if (cmd.op == bwb_pkg::MDU_DIV) begin
            hi_in  = {2'b00, dividend[2*N-1:N+1]};
            lo_in  = dividend[N:0];
            sat_in = ({1'b0, dividend[2*N-1:N+1]} >= opa);
         end else begin
            hi_in  = '0;
            lo_in  = {1'b0, opb};
            sat_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      a_ff   <= a_in;
      sat_ff <= sat_in;
   end

   always_comb begin
      sts.busy = busy_ff;
      sts.done = done_ff;
      if (op_ff == bwb_pkg::MDU_DIV) begin
         result = sat_ff ? {{(N-1){1'b0}}, {(N+1){1'b1}}} : {{(N-1){1'b0}}, lo_ff};
      end else begin
         result = {hi_ff[N-1:0], lo_ff[N:1]};
      end
   end

endmodule

>>> src/ball_wall_bounce_step.sv
// Point bouncing in the room [0,room_width] x [0,room_height], coordinates
// unsigned with 16 fraction bits. A start item (tuser 0) loads position and
// per-frame step, answers with the clamped position, or with a kind-2 error
// item when step_x^2+step_y^2 is not below both room_width^2 and
// room_height^2 (state then stays). A tick item (tuser 1) advances one frame
// and answers with zero, one or two wall impact items in time order, then the
// new position with tlast set. Every multiply and divide runs through one
// bit-serial unit, one bit per cycle, and the block takes one item at a
// time. A start item runs its four squarings through that unit. A tick item
// runs one multiply and one divide and sends one impact item for each axis
// whose wall is crossed. A waiting result item does not block the next
// request; a result waits only for the output register.
module ball_wall_bounce_step #(
   parameter int COORD_BITS = 24,
   localparam int REQ_W = ((4 * COORD_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [REQ_W-1:0]                   req_tdata,  // start_x, start_y, step_x, step_y
   input  logic                               req_tuser,  // opcode
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [RSP_W-1:0]                   rsp_tdata,  // point_x, point_y
   output logic [1:0]                         rsp_tuser,  // kind
   output logic                               rsp_tlast,
   // configuration
   input  logic                               csr_we,
   input  logic [bwb_pkg::CSR_ADDR_BITS-1:0]  csr_addr,
   input  logic [COORD_BITS-1:0]              csr_wdata
);

   localparam int N  = COORD_BITS;
   localparam int SW = COORD_BITS + 4;   // signed working width for coordinates
   localparam logic [N-1:0] RoomReset = N'(bwb_pkg::ROOM_RESET);
   localparam logic [N-1:0] SignBit   = {1'b1, {(N-1){1'b0}}};

   // ---------------------------------------------------------------------
   // helpers
   // ---------------------------------------------------------------------
   function automatic logic [N-1:0] mag_of(input logic [N-1:0] v);
      return v[N-1] ? (~v + 1'b1) : v;
   endfunction

   // most negative step negates to the largest positive one
   function automatic logic [N-1:0] neg_of(input logic [N-1:0] v);
      return (v == SignBit) ? ~SignBit : (~v + 1'b1);
   endfunction

   function automatic logic signed [SW-1:0] sext(input logic [N-1:0] v);
      return $signed({{4{v[N-1]}}, v});
   endfunction

   function automatic logic signed [SW-1:0] zext(input logic [N-1:0] v);
      return $signed({4'b0000, v});
   endfunction

   function automatic logic [N-1:0] clamp_pos(input logic signed [SW-1:0] v,
                                              input logic [N-1:0] lim);
      logic signed [SW-1:0] lim_s;
      lim_s = zext(lim);
      if (v[SW-1]) begin
         return '0;
      end else if (v > lim_s) begin
         return lim;
      end else begin
         return v[N-1:0];
      end
   endfunction

   // reflect about wall 0 or about the far wall
   function automatic logic signed [SW-1:0] mirror(input logic signed [SW-1:0] c,
                                                  input logic at_zero,
                                                  input logic [N-1:0] wall);
      logic signed [SW-1:0] two_w;
      two_w = $signed({3'b000, wall, 1'b0});
      return at_zero ? -c : (two_w - c);
   endfunction

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   bwb_pkg::state_type      state_ff, state_in;
   logic                    issued_ff, issued_in;

   logic [N-1:0]            room_w_ff, room_h_ff;
   logic [N-1:0]            cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [N-1:0]            vel_x_ff, vel_x_in, vel_y_ff, vel_y_in;

   logic [N-1:0]            st_x_ff, st_x_in, st_y_ff, st_y_in;
   logic [N-1:0]            stp_x_ff, stp_x_in, stp_y_ff, stp_y_in;
   logic [N-1:0]            mag_x_ff, mag_x_in, mag_y_ff, mag_y_in;
   logic [2*N:0]            sum_ff, sum_in;
   logic                    big_ff, big_in;

   logic signed [SW-1:0]    nx_ff, nx_in, ny_ff, ny_in;
   logic                    hx_ff, hx_in, hy_ff, hy_in;
   logic                    negx_ff, negx_in, negy_ff, negy_in;
   logic [N-1:0]            dx_ff, dx_in, dy_ff, dy_in;
   logic [2*N-1:0]          p1_ff, p1_in, p2_ff, p2_in;
   logic [N:0]              offx_ff, offx_in, offy_ff, offy_in;
   logic signed [SW-1:0]    ay_ff, ay_in, bx_ff, bx_in;
   logic                    xfirst_ff, xfirst_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_kind_ff, rsp_kind_in;
   logic [N-1:0]            rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic                    rsp_last_ff, rsp_last_in;

   // shared unit hookup
   bwb_pkg::mdu_cmd_type    mdu_cmd;
   bwb_pkg::mdu_sts_type    mdu_sts;
   logic [N-1:0]            mdu_opa, mdu_opb;
   logic [2*N-1:0]          mdu_dividend;
   logic [2*N-1:0]          mdu_result;

   logic                    op_state;
   logic                    rsp_free;
   logic                    a_first;
   logic [N-1:0]            a_px, a_py, b_px, b_py;

   bwb_mdu #(
      .COORD_BITS (COORD_BITS)
   ) u_mdu (
      .clock    (clock),
      .reset    (reset),
      .cmd      (mdu_cmd),
      .opa      (mdu_opa),
      .opb      (mdu_opb),
      .dividend (mdu_dividend),
      .sts      (mdu_sts),
      .result   (mdu_result)
   );

   // ---------------------------------------------------------------------
   // sequencer and datapath next values
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      issued_in    = issued_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      vel_x_in     = vel_x_ff;
      vel_y_in     = vel_y_ff;
      st_x_in      = st_x_ff;
      st_y_in      = st_y_ff;
      stp_x_in     = stp_x_ff;
      stp_y_in     = stp_y_ff;
      mag_x_in     = mag_x_ff;
      mag_y_in     = mag_y_ff;
      sum_in       = sum_ff;
      big_in       = big_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      hx_in        = hx_ff;
      hy_in        = hy_ff;
      negx_in      = negx_ff;
      negy_in      = negy_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      offx_in      = offx_ff;
      offy_in      = offy_ff;
      ay_in        = ay_ff;
      bx_in        = bx_ff;
      xfirst_in    = xfirst_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_last_in  = rsp_last_ff;

      mdu_cmd.op   = bwb_pkg::MDU_MUL;
      mdu_opa      = '0;
      mdu_opb      = '0;
      mdu_dividend = '0;

      rsp_free = ~rsp_valid_ff | rsp_tready;

      // impact point on the x wall (A) and on the y wall (B)
      a_first = hx_ff & (~hy_ff | xfirst_ff);
      a_px    = negx_ff ? '0 : room_w_ff;
      a_py    = clamp_pos(ay_ff, room_h_ff);
      b_px    = clamp_pos(bx_ff, room_w_ff);
      b_py    = negy_ff ? '0 : room_h_ff;

      // fire the shared unit once per operation state, advance on its done
      op_state = state_ff inside {bwb_pkg::ST_SQ_X, bwb_pkg::ST_SQ_Y, bwb_pkg::ST_SQ_W,
                                  bwb_pkg::ST_SQ_H, bwb_pkg::ST_MUL_X, bwb_pkg::ST_DIV_X,
                                  bwb_pkg::ST_MUL_Y, bwb_pkg::ST_DIV_Y};
      mdu_cmd.go = op_state & ~issued_ff;
      if (mdu_cmd.go) begin
         issued_in = 1'b1;
      end
      if (mdu_sts.done) begin
         issued_in = 1'b0;
      end

      case (state_ff)
         bwb_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               st_x_in  = req_tdata[N-1:0];
               st_y_in  = req_tdata[2*N-1:N];
               stp_x_in = req_tdata[3*N-1:2*N];
               stp_y_in = req_tdata[4*N-1:3*N];
               if (req_tuser == bwb_pkg::OP_START) begin
                  mag_x_in = mag_of(req_tdata[3*N-1:2*N]);
                  mag_y_in = mag_of(req_tdata[4*N-1:3*N]);
                  state_in = bwb_pkg::ST_SQ_X;
               end else begin
                  state_in = bwb_pkg::ST_CLAMP;
               end
            end
         end

         // step length check: mx^2 + my^2 against W^2 and H^2
         bwb_pkg::ST_SQ_X: begin
            mdu_opa = mag_x_ff;
            mdu_opb = mag_x_ff;
            if (mdu_sts.done) begin
               sum_in   = {1'b0, mdu_result};
               state_in = bwb_pkg::ST_SQ_Y;
            end
         end
         bwb_pkg::ST_SQ_Y: begin
            mdu_opa = mag_y_ff;
            mdu_opb = mag_y_ff;
            if (mdu_sts.done) begin
               sum_in   = sum_ff + {1'b0, mdu_result};
               state_in = bwb_pkg::ST_SQ_W;
            end
         end
         bwb_pkg::ST_SQ_W: begin
            mdu_opa = room_w_ff;
            mdu_opb = room_w_ff;
            if (mdu_sts.done) begin
               big_in   = (sum_ff >= {1'b0, mdu_result});
               state_in = bwb_pkg::ST_SQ_H;
            end
         end
         bwb_pkg::ST_SQ_H: begin
            mdu_opa = room_h_ff;
            mdu_opb = room_h_ff;
            if (mdu_sts.done) begin
               big_in   = big_ff | (sum_ff >= {1'b0, mdu_result});
               state_in = bwb_pkg::ST_START_OUT;
            end
         end
         bwb_pkg::ST_START_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (big_ff) begin
                  rsp_kind_in = bwb_pkg::KIND_ERR;
                  rsp_x_in    = '0;
                  rsp_y_in    = '0;
               end else begin
                  cur_x_in    = (st_x_ff > room_w_ff) ? room_w_ff : st_x_ff;
                  cur_y_in    = (st_y_ff > room_h_ff) ? room_h_ff : st_y_ff;
                  vel_x_in    = stp_x_ff;
                  vel_y_in    = stp_y_ff;
                  rsp_kind_in = bwb_pkg::KIND_POS;
                  rsp_x_in    = cur_x_in;
                  rsp_y_in    = cur_y_in;
               end
               state_in = bwb_pkg::ST_IDLE;
            end
         end

         // tick: pull a stale position back into a shrunk room
         bwb_pkg::ST_CLAMP: begin
            cur_x_in = (cur_x_ff > room_w_ff) ? room_w_ff : cur_x_ff;
            cur_y_in = (cur_y_ff > room_h_ff) ? room_h_ff : cur_y_ff;
            mag_x_in = mag_of(vel_x_ff);
            mag_y_in = mag_of(vel_y_ff);
            state_in = bwb_pkg::ST_EVAL;
         end
         bwb_pkg::ST_EVAL: begin
            nx_in    = zext(cur_x_ff) + sext(vel_x_ff);
            ny_in    = zext(cur_y_ff) + sext(vel_y_ff);
            state_in = bwb_pkg::ST_HIT;
         end
         // landing exactly on a wall is no crossing
         bwb_pkg::ST_HIT: begin
            negx_in = nx_ff[SW-1];
            negy_in = ny_ff[SW-1];
            hx_in   = nx_ff[SW-1] | (nx_ff > zext(room_w_ff));
            hy_in   = ny_ff[SW-1] | (ny_ff > zext(room_h_ff));
            dx_in   = nx_ff[SW-1] ? cur_x_ff : (room_w_ff - cur_x_ff);
            dy_in   = ny_ff[SW-1] ? cur_y_ff : (room_h_ff - cur_y_ff);
            if (hx_in) begin
               state_in = bwb_pkg::ST_MUL_X;
            end else if (hy_in) begin
               state_in = bwb_pkg::ST_MUL_Y;
            end else begin
               state_in = bwb_pkg::ST_PLACE;
            end
         end

         // offset along the x wall: my * dx / mx
         bwb_pkg::ST_MUL_X: begin
            mdu_opa = mag_y_ff;
            mdu_opb = dx_ff;
            if (mdu_sts.done) begin
               p1_in    = mdu_result;
               state_in = bwb_pkg::ST_DIV_X;
            end
         end
         bwb_pkg::ST_DIV_X: begin
            mdu_cmd.op   = bwb_pkg::MDU_DIV;
            mdu_opa      = mag_x_ff;
            mdu_dividend = p1_ff;
            if (mdu_sts.done) begin
               offx_in  = mdu_result[N:0];
               state_in = hy_ff ? bwb_pkg::ST_MUL_Y : bwb_pkg::ST_PLACE;
            end
         end
         // offset along the y wall: mx * dy / my
         bwb_pkg::ST_MUL_Y: begin
            mdu_opa = mag_x_ff;
            mdu_opb = dy_ff;
            if (mdu_sts.done) begin
               p2_in    = mdu_result;
               state_in = bwb_pkg::ST_DIV_Y;
            end
         end
         bwb_pkg::ST_DIV_Y: begin
            mdu_cmd.op   = bwb_pkg::MDU_DIV;
            mdu_opa      = mag_y_ff;
            mdu_dividend = p2_ff;
            if (mdu_sts.done) begin
               offy_in  = mdu_result[N:0];
               state_in = bwb_pkg::ST_PLACE;
            end
         end

         // impact coordinates; dx*my against dy*mx orders the two walls
         bwb_pkg::ST_PLACE: begin
            ay_in = vel_y_ff[N-1] ? (zext(cur_y_ff) - $signed({3'b000, offx_ff}))
                                  : (zext(cur_y_ff) + $signed({3'b000, offx_ff}));
            bx_in = vel_x_ff[N-1] ? (zext(cur_x_ff) - $signed({3'b000, offy_ff}))
                                  : (zext(cur_x_ff) + $signed({3'b000, offy_ff}));
            xfirst_in = (p1_ff <= p2_ff);
            state_in  = bwb_pkg::ST_MIRROR;
         end
         // the later impact lies beyond the earlier wall: fold it back
         bwb_pkg::ST_MIRROR: begin
            if (hx_ff & hy_ff) begin
               if (xfirst_ff) begin
                  bx_in = mirror(bx_ff, negx_ff, room_w_ff);
               end else begin
                  ay_in = mirror(ay_ff, negy_ff, room_h_ff);
               end
            end
            if (hx_ff) begin
               nx_in = mirror(nx_ff, negx_ff, room_w_ff);
            end
            if (hy_ff) begin
               ny_in = mirror(ny_ff, negy_ff, room_h_ff);
            end
            state_in = (hx_ff | hy_ff) ? bwb_pkg::ST_EMIT_1 : bwb_pkg::ST_EMIT_POS;
         end

         bwb_pkg::ST_EMIT_1: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = bwb_pkg::KIND_IMPACT;
               rsp_last_in  = 1'b0;
               rsp_x_in     = a_first ? a_px : b_px;
               rsp_y_in     = a_first ? a_py : b_py;
               state_in     = (hx_ff & hy_ff) ? bwb_pkg::ST_EMIT_2 : bwb_pkg::ST_EMIT_POS;
            end
         end
         bwb_pkg::ST_EMIT_2: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = bwb_pkg::KIND_IMPACT;
               rsp_last_in  = 1'b0;
               rsp_x_in     = a_first ? b_px : a_px;
               rsp_y_in     = a_first ? b_py : a_py;
               state_in     = bwb_pkg::ST_EMIT_POS;
            end
         end
         bwb_pkg::ST_EMIT_POS: begin
            if (rsp_free) begin
               cur_x_in = clamp_pos(nx_ff, room_w_ff);
               cur_y_in = clamp_pos(ny_ff, room_h_ff);
               if (hx_ff) begin
                  vel_x_in = neg_of(vel_x_ff);
               end
               if (hy_ff) begin
                  vel_y_in = neg_of(vel_y_ff);
               end
               rsp_valid_in = 1'b1;
               rsp_kind_in  = bwb_pkg::KIND_POS;
               rsp_last_in  = 1'b1;
               rsp_x_in     = cur_x_in;
               rsp_y_in     = cur_y_in;
               state_in     = bwb_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = bwb_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // state registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bwb_pkg::ST_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         vel_x_ff     <= '0;
         vel_y_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         vel_x_ff     <= vel_x_in;
         vel_y_ff     <= vel_y_in;
      end
   end

   // room size registers, to be written only while the block is idle; the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         room_w_ff <= RoomReset;
         room_h_ff <= RoomReset;
      end else if (csr_we) begin
         case (csr_addr)
            bwb_pkg::REG_ROOM_WIDTH:  room_w_ff <= csr_wdata;
            bwb_pkg::REG_ROOM_HEIGHT: room_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // working and result payload, no reset
   always_ff @(posedge clock) begin
      st_x_ff     <= st_x_in;
      st_y_ff     <= st_y_in;
      stp_x_ff    <= stp_x_in;
      stp_y_ff    <= stp_y_in;
      mag_x_ff    <= mag_x_in;
      mag_y_ff    <= mag_y_in;
      sum_ff      <= sum_in;
      big_ff      <= big_in;
      nx_ff       <= nx_in;
      ny_ff       <= ny_in;
      hx_ff       <= hx_in;
      hy_ff       <= hy_in;
      negx_ff     <= negx_in;
      negy_ff     <= negy_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
      offx_ff     <= offx_in;
      offy_ff     <= offy_in;
      ay_ff       <= ay_in;
      bx_ff       <= bx_in;
      xfirst_ff   <= xfirst_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_last_ff <= rsp_last_in;
   end

   // ---------------------------------------------------------------------
   // ports
   // ---------------------------------------------------------------------
   assign req_tready = (state_ff == bwb_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_y_ff, rsp_x_ff});
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> test/ball_wall_bounce_step_tb.sv
`timescale 1ns / 1ps

module ball_wall_bounce_step_tb;

   localparam int COORD_W = 24;
   localparam int REQ_W   = ((4 * COORD_W + 7) / 8) * 8;
   localparam int RSP_W   = ((2 * COORD_W + 7) / 8) * 8;
   localparam int ROOM_MAX = (1 << COORD_W) - 1;
   localparam int ROOM_MIN = 65536;
   localparam int STEP_MAX = (1 << (COORD_W - 1)) - 1;

   // one result item as the block should produce it
   typedef struct packed {
      logic [1:0]         kind;
      logic [COORD_W-1:0] px;
      logic [COORD_W-1:0] py;
      logic               last;
   } point_type;

   logic               clock;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata  = '0;  // start_x, start_y, step_x, step_y
   logic               req_tuser  = 1'b0;  // opcode
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;  // point_x, point_y
   logic [1:0]         rsp_tuser;  // kind
   logic               rsp_tlast;
   logic               csr_we     = 1'b0;
   logic [bwb_pkg::CSR_ADDR_BITS-1:0] csr_addr = '0;
   logic [COORD_W-1:0] csr_wdata  = '0;

   // predictor copy of the block's registers and motion state
   logic [COORD_W-1:0] room_w = COORD_W'(bwb_pkg::ROOM_RESET);
   logic [COORD_W-1:0] room_h = COORD_W'(bwb_pkg::ROOM_RESET);
   logic [COORD_W-1:0] pos_x = '0, pos_y = '0, vel_x = '0, vel_y = '0;

   point_type expected_points[$];
   int     mismatch_count = 0;
   int     random_items   = 0;
   bit     no_idle        = 1'b0;

   ball_wall_bounce_step dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // ---------------------------------------------------------------------
   // Motion predictor
   // ---------------------------------------------------------------------
   function automatic longint wide(input logic [COORD_W-1:0] v);
      return longint'({{(64-COORD_W){1'b0}}, v});
   endfunction

   // magnitude of a two's complement step; the most negative one gives 2^23
   function automatic longint step_mag(input logic [COORD_W-1:0] v);
      logic [COORD_W-1:0] n;
      n = ~v + 1'b1;
      return v[COORD_W-1] ? wide(n) : wide(v);
   endfunction

   function automatic longint step_signed(input logic [COORD_W-1:0] v);
      return v[COORD_W-1] ? -step_mag(v) : step_mag(v);
   endfunction

   // negate, saturating the most negative step to the largest positive one
   function automatic logic [COORD_W-1:0] step_negate(input logic [COORD_W-1:0] v);
      if (v == {1'b1, {(COORD_W-1){1'b0}}})
         return {1'b0, {(COORD_W-1){1'b1}}};
      return ~v + 1'b1;
   endfunction

   function automatic logic [COORD_W-1:0] clamp_room(input longint v,
                                                      input logic [COORD_W-1:0] hi);
      if (v < 0)
         return '0;
      if (v > wide(hi))
         return hi;
      return v[COORD_W-1:0];
   endfunction

   function automatic longint reflect(input longint c, input longint wall);
      return (wall == 0) ? -c : 2 * wall - c;
   endfunction

   function automatic void push_point(input logic [1:0] kind, input longint x,
                                      input longint y, input logic last);
      point_type p;
      p.kind = kind;
      p.px   = clamp_room(x, room_w);
      p.py   = clamp_room(y, room_h);
      p.last = last;
      expected_points.insert(expected_points.size(), p);
   endfunction

   // Work out every result item of one accepted request and update the state.
   function automatic void predict_motion(input logic op,
                                          input logic [COORD_W-1:0] in_x, in_y,
                                          input logic [COORD_W-1:0] in_vx, in_vy);
      longint w, h, mx, my, sum, px, py, sx, sy, nx, ny, wx, wy;
      longint dx, dy, off, ax, ay, bx, by;
      bit hx, hy;
      w = wide(room_w);
      h = wide(room_h);
      dx = 0; dy = 0; ax = 0; ay = 0; bx = 0; by = 0;
      if (op == bwb_pkg::OP_START) begin
         mx = step_mag(in_vx);
         my = step_mag(in_vy);
         sum = mx * mx + my * my;
         // refuse a step not shorter than both room sizes; keep the state
         if (sum >= w * w || sum >= h * h) begin
            push_point(bwb_pkg::KIND_ERR, 0, 0, 1'b1);
         end else begin
            pos_x = clamp_room(wide(in_x), room_w);
            pos_y = clamp_room(wide(in_y), room_h);
            vel_x = in_vx;
            vel_y = in_vy;
            push_point(bwb_pkg::KIND_POS, wide(pos_x), wide(pos_y), 1'b1);
         end
      end else begin
         // pull a position left outside by a shrunk room back in first
         if (pos_x > room_w) pos_x = room_w;
         if (pos_y > room_h) pos_y = room_h;
         px = wide(pos_x);
         py = wide(pos_y);
         sx = step_signed(vel_x);
         sy = step_signed(vel_y);
         mx = step_mag(vel_x);
         my = step_mag(vel_y);
         nx = px + sx;
         ny = py + sy;
         hx = (nx < 0) || (nx > w);
         hy = (ny < 0) || (ny > h);
         wx = (nx < 0) ? 0 : w;
         wy = (ny < 0) ? 0 : h;
         if (hx) begin
            dx  = (nx < 0) ? px : w - px;
            off = (my * dx) / mx;
            ax  = wx;
            ay  = (sy < 0) ? py - off : py + off;
         end
         if (hy) begin
            dy  = (ny < 0) ? py : h - py;
            off = (mx * dy) / my;
            by  = wy;
            bx  = (sx < 0) ? px - off : px + off;
         end
         if (hx && hy) begin
            // earlier wall first, x wall on a tie; mirror the later point
            if (dx * my <= dy * mx) begin
               bx = reflect(bx, wx);
               push_point(bwb_pkg::KIND_IMPACT, ax, ay, 1'b0);
               push_point(bwb_pkg::KIND_IMPACT, bx, by, 1'b0);
            end else begin
               ay = reflect(ay, wy);
               push_point(bwb_pkg::KIND_IMPACT, bx, by, 1'b0);
               push_point(bwb_pkg::KIND_IMPACT, ax, ay, 1'b0);
            end
         end else if (hx) begin
            push_point(bwb_pkg::KIND_IMPACT, ax, ay, 1'b0);
         end else if (hy) begin
            push_point(bwb_pkg::KIND_IMPACT, bx, by, 1'b0);
         end
         if (hx) begin
            nx = reflect(nx, wx);
            vel_x = step_negate(vel_x);
         end
         if (hy) begin
            ny = reflect(ny, wy);
            vel_y = step_negate(vel_y);
         end
         pos_x = clamp_room(nx, room_w);
         pos_y = clamp_room(ny, room_h);
         push_point(bwb_pkg::KIND_POS, wide(pos_x), wide(pos_y), 1'b1);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Driving and checking
   // ---------------------------------------------------------------------

   // Present one request item, idling at random beforehand, and predict its
   // results at the edge that accepts it.
   task automatic send_item(input logic op, input int ix, input int iy,
                            input int ivx, input int ivy);
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {COORD_W'(ivy), COORD_W'(ivx), COORD_W'(iy), COORD_W'(ix)};
      do @(posedge clock); while (!req_tready);
      predict_motion(op, COORD_W'(ix), COORD_W'(iy), COORD_W'(ivx), COORD_W'(ivy));
   endtask

   // tick items carry random data, which the block must ignore
   task automatic tick();
      send_item(bwb_pkg::OP_TICK, $urandom, $urandom, $urandom, $urandom);
   endtask

   // drop valid and hold until every predicted item has come back
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_points.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_room(input logic [bwb_pkg::CSR_ADDR_BITS-1:0] addr,
                             input int value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= COORD_W'(value);
      @(posedge clock);
      if (addr == bwb_pkg::REG_ROOM_WIDTH)
         room_w = COORD_W'(value);
      else
         room_h = COORD_W'(value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // result side stalls at random, with a probability of 15 in a hundred
   always @(negedge clock)
      rsp_tready <= no_idle || ($urandom_range(99) >= 15);

   // compare every accepted result item with the oldest prediction
   always @(posedge clock) begin : check_results
      point_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_points.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: kind %0d x %h y %h last %b",
                        rsp_tuser, rsp_tdata[COORD_W-1:0],
                        rsp_tdata[2*COORD_W-1:COORD_W], rsp_tlast);
         end else begin
            want = expected_points.pop_front();
            if (rsp_tuser !== want.kind || rsp_tdata[COORD_W-1:0] !== want.px ||
                rsp_tdata[2*COORD_W-1:COORD_W] !== want.py || rsp_tlast !== want.last)
            begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("exp kind %0d x %h y %h last %b / act kind %0d x %h y %h last %b",
                           want.kind, want.px, want.py, want.last,
                           rsp_tuser, rsp_tdata[COORD_W-1:0],
                           rsp_tdata[2*COORD_W-1:COORD_W], rsp_tlast);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Start echo, clamping of the start point and refusal of long steps,
   // in the room of 5.0 x 5.0 that reset leaves.
   task automatic test_start_echo_and_refusal();
      send_item(bwb_pkg::OP_START, 0, 0, 65536, 32768);
      send_item(bwb_pkg::OP_START, ROOM_MAX, ROOM_MAX, 0, 0);
      // step exactly as long as the room: refused
      send_item(bwb_pkg::OP_START, 100, 200, 327680, 0);
      // most negative step: refused, state kept, so the tick stays put
      send_item(bwb_pkg::OP_START, 100, 200, 0, -8388608);
      tick();
      // longest step still accepted, then both walls at the same time
      send_item(bwb_pkg::OP_START, 163840, 163840, 231704, 231704);
      tick();
   endtask

   // Bounces off one wall at a time, and landing right on a wall.
   task automatic test_single_wall_bounce();
      send_item(bwb_pkg::OP_START, 262144, 163840, 131072, 0);
      tick();
      tick();
      // land on the right wall: no impact yet, the next tick crosses it
      send_item(bwb_pkg::OP_START, 262144, 0, 65536, 0);
      tick();
      tick();
      // top wall on a diagonal
      send_item(bwb_pkg::OP_START, 65536, 262144, 32768, 131072);
      tick();
      // left wall, then bottom wall
      send_item(bwb_pkg::OP_START, 32768, 32768, -65536, -16384);
      tick();
      send_item(bwb_pkg::OP_START, 100000, 10000, 5000, -40000);
      tick();
   endtask

   // Two walls in one frame: x first, y first, and the exact corner.
   task automatic test_corner_bounce();
      send_item(bwb_pkg::OP_START, 262144, 262144, 131072, 131072);
      tick();
      send_item(bwb_pkg::OP_START, 294912, 163840, 65536, 196608);
      tick();
      send_item(bwb_pkg::OP_START, 32768, 8192, -131072, -65536);
      tick();
   endtask

   // Largest and smallest rooms, the most negative step and a room that
   // shrinks under a moving point.
   task automatic test_room_extremes();
      wait_idle();
      write_room(bwb_pkg::REG_ROOM_WIDTH, ROOM_MAX);
      write_room(bwb_pkg::REG_ROOM_HEIGHT, ROOM_MAX);
      send_item(bwb_pkg::OP_START, ROOM_MAX, ROOM_MAX, 0, 0);
      // most negative steps bounce and saturate to the largest positive ones
      send_item(bwb_pkg::OP_START, 65536, 100, -8388608, -8388608);
      tick();
      tick();
      send_item(bwb_pkg::OP_START, 16000000, 16000000, 8000000, -3000000);
      wait_idle();
      write_room(bwb_pkg::REG_ROOM_WIDTH, ROOM_MIN);
      write_room(bwb_pkg::REG_ROOM_HEIGHT, ROOM_MIN);
      // position now outside the room and step far larger than it
      tick();
      send_item(bwb_pkg::OP_START, 0, 0, 0, 0);
      tick();
      send_item(bwb_pkg::OP_START, 0, 0, 65536, 0);
   endtask

   function automatic int pick_room();
      case ($urandom_range(3))
         0:       return ROOM_MIN + int'($urandom_range(1 << 20));
         1:       return int'($urandom_range(ROOM_MAX, ROOM_MIN));
         2:       return ROOM_MAX;
         default: return bwb_pkg::ROOM_RESET;
      endcase
   endfunction

   // Mostly start-then-tick trajectories with random content, some raw noise,
   // occasional room changes, and a middle stretch with no idling at all.
   task automatic test_random_trajectories();
      int lim, n_ticks, sx, sy, ix, iy;
      while (random_items < 65) begin
         no_idle = (random_items >= 20 && random_items < 45);
         if ($urandom_range(4) == 0) begin
            wait_idle();
            write_room(bwb_pkg::REG_ROOM_WIDTH, pick_room());
            write_room(bwb_pkg::REG_ROOM_HEIGHT, pick_room());
         end
         if ($urandom_range(4) != 0) begin
            lim = ((room_w < room_h) ? int'(room_w) : int'(room_h)) / 10 * 7;
            if (lim > STEP_MAX) lim = STEP_MAX;
            sx = int'($urandom_range(2 * lim)) - lim;
            sy = int'($urandom_range(2 * lim)) - lim;
            if ($urandom_range(3) != 0) begin
               ix = int'($urandom_range(room_w));
               iy = int'($urandom_range(room_h));
            end else begin
               ix = $urandom & ROOM_MAX;
               iy = $urandom & ROOM_MAX;
            end
            send_item(bwb_pkg::OP_START, ix, iy, sx, sy);
            random_items++;
            n_ticks = $urandom_range(8, 1);
            repeat (n_ticks) begin
               // shrink or grow the room under the point now and then
               if ($urandom_range(9) == 0) begin
                  wait_idle();
                  write_room($urandom_range(1) ? bwb_pkg::REG_ROOM_HEIGHT
                                               : bwb_pkg::REG_ROOM_WIDTH,
                             pick_room());
               end
               tick();
               random_items++;
            end
         end else begin
            repeat ($urandom_range(3, 1)) begin
               send_item($urandom_range(1) ? bwb_pkg::OP_TICK : bwb_pkg::OP_START,
                         $urandom, $urandom, $urandom, $urandom);
               random_items++;
            end
         end
      end
      no_idle = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      // hold reset, release at a falling edge
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_start_echo_and_refusal();
      test_single_wall_bounce();
      test_corner_bounce();
      test_room_extremes();
      test_random_trajectories();

      // drain, then keep the clock running so that a stray extra result is still caught
      wait_idle();
      repeat (150) @(posedge clock);
      if (mismatch_count == 0 && expected_points.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // hard stop well beyond the slowest correct run
   initial begin
      #400000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

>>> ball_wall_bounce_step.f
src/bwb_pkg.sv
src/bwb_mdu.sv
src/ball_wall_bounce_step.sv
test/ball_wall_bounce_step_tb.sv
